// File: src/bqe_pkg.sv
`default_nettype none
package bqe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ALPHA_FRAC = 16;

    // widths of the working values
    localparam int VW = (2 * FRAC_BITS + 3 > 34) ? 2 * FRAC_BITS + 3 : 34;
    localparam int NW = FRAC_BITS + 2;
    localparam int HW = 33;
    localparam int CW = HW + 2;
    localparam int MULW = 33;
    localparam int PW = 2 * MULW;
    localparam int SUMW = 62;
    localparam int LENW = 31;
    localparam int DW = 64;
    localparam int AW = ALPHA_FRAC + 1;
    localparam int STW = 6;

    localparam int NORM_HI = 30;
    localparam int NORM_LO = 29;
    localparam int COARSE = 8;

    localparam logic [STW-1:0] SQRT_STEPS = STW'(32);
    localparam logic [STW-1:0] DIV_STEPS = STW'(FRAC_BITS + 1);
    localparam logic [STW-1:0] ALPHA_STEPS = STW'(ALPHA_FRAC + 1);
    localparam logic [AW-1:0] ALPHA_ONE = AW'(1) << ALPHA_FRAC;

    localparam logic [1:0] REG_CAMERA_X = 2'd0;
    localparam logic [1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [1:0] REG_CAMERA_Z = 2'd2;
    localparam logic [1:0] REG_FADE_IN_TIME = 2'd3;
    localparam logic [31:0] FADE_RESET = 32'd65536;

    localparam logic [4:0] OP_NOP = 5'd0;
    localparam logic [4:0] OP_CAPTURE = 5'd1;
    localparam logic [4:0] OP_LOAD_T = 5'd2;
    localparam logic [4:0] OP_LOAD_R = 5'd3;
    localparam logic [4:0] OP_CROSS = 5'd4;
    localparam logic [4:0] OP_MAG = 5'd5;
    localparam logic [4:0] OP_SHIFT = 5'd6;
    localparam logic [4:0] OP_SQ = 5'd7;
    localparam logic [4:0] OP_SQRT_GO = 5'd8;
    localparam logic [4:0] OP_LEN = 5'd9;
    localparam logic [4:0] OP_DIV_GO = 5'd10;
    localparam logic [4:0] OP_DIV_WR = 5'd11;
    localparam logic [4:0] OP_ZERO = 5'd12;
    localparam logic [4:0] OP_HALF = 5'd13;
    localparam logic [4:0] OP_ALPHA_ONE = 5'd14;
    localparam logic [4:0] OP_ALPHA_GO = 5'd15;
    localparam logic [4:0] OP_ALPHA_WR = 5'd16;
    localparam logic [4:0] OP_EMIT = 5'd17;

    localparam logic [1:0] NSEL_T = 2'd0;
    localparam logic [1:0] NSEL_R = 2'd1;
    localparam logic [1:0] NSEL_U = 2'd2;

    typedef struct packed {
        logic        start_frame;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0] age;
        logic [31:0] quad_size;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_z;
        logic        tex_u;
        logic        tex_v;
        logic [16:0] alpha;
        logic [15:0] vertex_index;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] idx;
        logic [1:0] nsel;
    } cmd_t;

    typedef struct packed {
        logic dsu_done;
        logic in_range;
        logic is_zero;
        logic age_ge;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// File: src/bqe_dsu.sv
`default_nettype none
module bqe_dsu (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       sqrt_mode,
    input  wire logic [bqe_pkg::DW-1:0]     a,
    input  wire logic [31:0]                b,
    input  wire logic [bqe_pkg::STW-1:0]    steps,
    output logic                            done,
    output logic [31:0]                     result
);

    localparam int DW = bqe_pkg::DW;

    logic                       busy_reg;
    logic                       done_reg;
    logic                       mode_reg;
    logic [bqe_pkg::STW-1:0]    cnt_reg;
    logic [DW-1:0]              x_reg;
    logic [DW-1:0]              res_reg;
    logic [DW-1:0]              bit_reg;
    logic [31:0]                rem_reg;
    logic [31:0]                d_reg;

    logic [DW-1:0]              trial;
    logic                       sq_ge;
    logic [32:0]                rem2;
    logic                       dv_ge;
    logic [32:0]                rem_diff;
    logic [DW-1:0]              a_hi;

    always_comb begin
        trial = res_reg + bit_reg;
        sq_ge = x_reg >= trial;
        rem2 = {rem_reg, x_reg[DW-1]};
        dv_ge = rem2 >= {1'b0, d_reg};
        rem_diff = rem2 - {1'b0, d_reg};
        a_hi = a >> steps;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == bqe_pkg::STW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= steps;
                mode_reg <= sqrt_mode;
                res_reg <= '0;
                d_reg <= b;
                bit_reg <= DW'(1) << 62;
                if (sqrt_mode) begin
                    x_reg <= a;
                end else begin
                    // remainder starts below the divisor, low bits come in msb first
                    rem_reg <= a_hi[31:0];
                    x_reg <= a << (7'(DW) - {1'b0, steps});
                end
            end else if (busy_reg) begin
                if (mode_reg) begin
                    if (sq_ge) begin
                        x_reg <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end else begin
                    x_reg <= x_reg << 1;
                    res_reg <= {res_reg[DW-2:0], dv_ge};
                    rem_reg <= dv_ge ? rem_diff[31:0] : rem2[31:0];
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bqe_pkg::STW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign result = res_reg[31:0];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divide/sqrt unit restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished run");

endmodule
`default_nettype wire

// File: src/bqe_datapath.sv
`default_nettype none
module bqe_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bqe_pkg::cmd_t          cmd,
    output bqe_pkg::status_t            status,
    input  wire bqe_pkg::in_word_t      s_data,
    input  wire logic                   m_ready,
    output logic                        m_valid,
    output bqe_pkg::out_word_t          m_data,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [31:0]            cfg_wdata
);

    localparam int VW = bqe_pkg::VW;
    localparam int NW = bqe_pkg::NW;
    localparam int HW = bqe_pkg::HW;
    localparam int CW = bqe_pkg::CW;
    localparam int MULW = bqe_pkg::MULW;
    localparam int PW = bqe_pkg::PW;
    localparam int FB = bqe_pkg::FRAC_BITS;
    localparam int NORM_TOP = bqe_pkg::NORM_HI;

    logic signed [31:0]     cam_reg [3];
    logic [31:0]            fade_reg;
    logic signed [31:0]     p_reg [3];
    logic [31:0]            age_reg;
    logic [31:0]            size_reg;
    logic signed [VW-1:0]   vec_reg [3];
    logic [VW-1:0]          m_reg [3];
    logic                   sgn_reg [3];
    logic signed [NW-1:0]   t_reg [3];
    logic signed [NW-1:0]   r_reg [3];
    logic signed [NW-1:0]   u_reg [3];
    logic [bqe_pkg::SUMW-1:0] sum_reg;
    logic [bqe_pkg::LENW-1:0] len_reg;
    logic signed [HW-1:0]   ho_reg [6];
    logic [bqe_pkg::AW-1:0] alpha_reg;
    logic [15:0]            vcount_reg;
    bqe_pkg::out_word_t     out_reg;
    logic                   out_valid_reg;

    logic [1:0]             ii;
    logic [VW-1:0]          mx;
    logic                   out_free;
    logic signed [MULW-1:0] mul_a;
    logic signed [MULW-1:0] mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [NW-1:0]   hc;
    logic [NW-1:0]          habs;
    logic [HW-2:0]          hq;
    logic signed [HW-1:0]   hval;
    logic [NW-2:0]          dq;
    logic signed [NW-1:0]   dval;
    logic signed [CW-1:0]   csum [3];
    logic signed [31:0]     cor [3];
    logic                   neg_r;
    logic                   neg_u;

    logic                   dsu_start;
    logic                   dsu_sqrt;
    logic [bqe_pkg::DW-1:0] dsu_a;
    logic [31:0]            dsu_b;
    logic [bqe_pkg::STW-1:0] dsu_steps;
    logic                   dsu_done;
    logic [31:0]            dsu_res;

    assign ii = cmd.idx[1:0];
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
    end

    // half-size offset operand: r for 0..2, u for 3..5
    always_comb begin
        case (cmd.idx)
            3'd0: hc = r_reg[0];
            3'd1: hc = r_reg[1];
            3'd2: hc = r_reg[2];
            3'd3: hc = u_reg[0];
            3'd4: hc = u_reg[1];
            default: hc = u_reg[2];
        endcase
        habs = hc[NW-1] ? NW'(-hc) : NW'(hc);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            bqe_pkg::OP_SQ: begin
                mul_a = $signed({1'b0, m_reg[ii][MULW-2:0]});
                mul_b = $signed({1'b0, m_reg[ii][MULW-2:0]});
            end
            bqe_pkg::OP_CROSS: begin
                case (ii)
                    2'd0: begin mul_a = MULW'(t_reg[1]); mul_b = MULW'(r_reg[2]); end
                    2'd1: begin mul_a = MULW'(t_reg[2]); mul_b = MULW'(r_reg[0]); end
                    2'd2: begin mul_a = MULW'(t_reg[0]); mul_b = MULW'(r_reg[2]); end
                    default: begin mul_a = MULW'(t_reg[1]); mul_b = MULW'(r_reg[0]); end
                endcase
            end
            bqe_pkg::OP_HALF: begin
                mul_a = $signed({{(MULW-NW){1'b0}}, habs});
                mul_b = $signed({1'b0, size_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        hq = mul_p[FB+1 +: HW-1];
        hval = hc[NW-1] ? -$signed({1'b0, hq}) : $signed({1'b0, hq});
        dq = dsu_res[NW-2:0];
        dval = sgn_reg[ii] ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
    end

    always_comb begin
        dsu_start = 1'b0;
        dsu_sqrt = 1'b0;
        dsu_a = '0;
        dsu_b = '0;
        dsu_steps = bqe_pkg::DIV_STEPS;
        unique case (cmd.op)
            bqe_pkg::OP_SQRT_GO: begin
                dsu_start = 1'b1;
                dsu_sqrt = 1'b1;
                dsu_a = bqe_pkg::DW'(sum_reg);
                dsu_steps = bqe_pkg::SQRT_STEPS;
            end
            bqe_pkg::OP_DIV_GO: begin
                dsu_start = 1'b1;
                dsu_a = bqe_pkg::DW'(m_reg[ii][NORM_TOP-1:0]) << FB;
                dsu_b = 32'(len_reg);
            end
            bqe_pkg::OP_ALPHA_GO: begin
                dsu_start = 1'b1;
                dsu_a = bqe_pkg::DW'(age_reg) << bqe_pkg::ALPHA_FRAC;
                dsu_b = fade_reg;
                dsu_steps = bqe_pkg::ALPHA_STEPS;
            end
            default: begin
                dsu_start = 1'b0;
            end
        endcase
    end

    // corner k: r negated for corners 0 and 3, u negated for corners 0 and 1
    always_comb begin
        neg_r = (ii == 2'd0) || (ii == 2'd3);
        neg_u = (ii == 2'd0) || (ii == 2'd1);
        for (int i = 0; i < 3; i++) begin
            csum[i] = CW'(p_reg[i])
                    + (neg_r ? -CW'(ho_reg[i]) : CW'(ho_reg[i]))
                    + (neg_u ? -CW'(ho_reg[3+i]) : CW'(ho_reg[3+i]));
            if (csum[i][CW-1:31] == '0 || csum[i][CW-1:31] == '1) begin
                cor[i] = csum[i][31:0];
            end else begin
                cor[i] = csum[i][CW-1] ? 32'sh80000000 : 32'sh7fffffff;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
            fade_reg <= bqe_pkg::FADE_RESET;
            vcount_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    bqe_pkg::REG_CAMERA_X: cam_reg[0] <= cfg_wdata;
                    bqe_pkg::REG_CAMERA_Y: cam_reg[1] <= cfg_wdata;
                    bqe_pkg::REG_CAMERA_Z: cam_reg[2] <= cfg_wdata;
                    bqe_pkg::REG_FADE_IN_TIME: fade_reg <= cfg_wdata;
                endcase
            end
            if (cmd.op == bqe_pkg::OP_EMIT) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (cmd.op)
                bqe_pkg::OP_CAPTURE: begin
                    p_reg[0] <= s_data.pos_x;
                    p_reg[1] <= s_data.pos_y;
                    p_reg[2] <= s_data.pos_z;
                    age_reg <= s_data.age;
                    size_reg <= s_data.quad_size;
                    if (s_data.start_frame) vcount_reg <= '0;
                end
                bqe_pkg::OP_LOAD_T: begin
                    for (int i = 0; i < 3; i++) vec_reg[i] <= VW'(cam_reg[i]) - VW'(p_reg[i]);
                end
                bqe_pkg::OP_LOAD_R: begin
                    vec_reg[0] <= VW'(t_reg[2]);
                    vec_reg[1] <= '0;
                    vec_reg[2] <= -VW'(t_reg[0]);
                end
                bqe_pkg::OP_CROSS: begin
                    case (ii)
                        2'd0: vec_reg[0] <= VW'(mul_p);
                        2'd1: vec_reg[1] <= VW'(mul_p);
                        2'd2: vec_reg[1] <= vec_reg[1] - VW'(mul_p);
                        default: vec_reg[2] <= -VW'(mul_p);
                    endcase
                end
                bqe_pkg::OP_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        m_reg[i] <= vec_reg[i][VW-1] ? VW'(-vec_reg[i]) : VW'(vec_reg[i]);
                        sgn_reg[i] <= vec_reg[i][VW-1];
                    end
                end
                bqe_pkg::OP_SHIFT: begin
                    // right steps truncate one bit at a time, same as one big shift
                    for (int i = 0; i < 3; i++) begin
                        if (mx[VW-1:bqe_pkg::NORM_HI] != '0) begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end else if (mx[VW-1:bqe_pkg::NORM_LO-bqe_pkg::COARSE] == '0) begin
                            m_reg[i] <= m_reg[i] << bqe_pkg::COARSE;
                        end else begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                end
                bqe_pkg::OP_SQ: begin
                    sum_reg <= (cmd.idx == 3'd0 ? '0 : sum_reg) + mul_p[bqe_pkg::SUMW-1:0];
                end
                bqe_pkg::OP_LEN: len_reg <= dsu_res[bqe_pkg::LENW-1:0];
                bqe_pkg::OP_DIV_WR: begin
                    unique case (cmd.nsel)
                        bqe_pkg::NSEL_T: t_reg[ii] <= dval;
                        bqe_pkg::NSEL_R: r_reg[ii] <= dval;
                        default: u_reg[ii] <= dval;
                    endcase
                end
                bqe_pkg::OP_ZERO: begin
                    for (int i = 0; i < 3; i++) begin
                        unique case (cmd.nsel)
                            bqe_pkg::NSEL_T: t_reg[i] <= '0;
                            bqe_pkg::NSEL_R: r_reg[i] <= '0;
                            default: u_reg[i] <= '0;
                        endcase
                    end
                end
                bqe_pkg::OP_HALF: ho_reg[cmd.idx] <= hval;
                bqe_pkg::OP_ALPHA_ONE: alpha_reg <= bqe_pkg::ALPHA_ONE;
                bqe_pkg::OP_ALPHA_WR: alpha_reg <= dsu_res[bqe_pkg::AW-1:0];
                bqe_pkg::OP_EMIT: begin
                    out_reg.corner_x <= cor[0];
                    out_reg.corner_y <= cor[1];
                    out_reg.corner_z <= cor[2];
                    out_reg.tex_u <= (ii == 2'd1) || (ii == 2'd2);
                    out_reg.tex_v <= (ii == 2'd0) || (ii == 2'd1);
                    out_reg.alpha <= alpha_reg;
                    out_reg.vertex_index <= vcount_reg;
                    out_reg.last <= ii == 2'd3;
                    vcount_reg <= vcount_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    bqe_dsu u_dsu (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dsu_start),
        .sqrt_mode (dsu_sqrt),
        .a         (dsu_a),
        .b         (dsu_b),
        .steps     (dsu_steps),
        .done      (dsu_done),
        .result    (dsu_res)
    );

    always_comb begin
        status.dsu_done = dsu_done;
        status.in_range = (mx[VW-1:bqe_pkg::NORM_HI] == '0) && mx[bqe_pkg::NORM_LO];
        status.is_zero = mx == '0;
        status.age_ge = age_reg >= fade_reg;
        status.out_free = out_free;
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == bqe_pkg::OP_EMIT |-> out_free)
        else $error("vertex written over a pending word");
    a_len_normal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == bqe_pkg::OP_DIV_GO |-> len_reg[bqe_pkg::LENW-1:bqe_pkg::NORM_LO] != '0)
        else $error("length below normalized range");

endmodule
`default_nettype wire

// File: src/bqe_ctrl.sv
`default_nettype none
module bqe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bqe_pkg::status_t   status,
    output bqe_pkg::cmd_t           cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOADT = 5'd1;
    localparam logic [4:0] S_MAG   = 5'd2;
    localparam logic [4:0] S_CHK   = 5'd3;
    localparam logic [4:0] S_SHIFT = 5'd4;
    localparam logic [4:0] S_SQ    = 5'd5;
    localparam logic [4:0] S_SQRT  = 5'd6;
    localparam logic [4:0] S_SQW   = 5'd7;
    localparam logic [4:0] S_DIV   = 5'd8;
    localparam logic [4:0] S_DIVW  = 5'd9;
    localparam logic [4:0] S_NEXT  = 5'd10;
    localparam logic [4:0] S_LOADR = 5'd11;
    localparam logic [4:0] S_CROSS = 5'd12;
    localparam logic [4:0] S_HALF  = 5'd13;
    localparam logic [4:0] S_ALPHA = 5'd14;
    localparam logic [4:0] S_ALW   = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [1:0] nsel_reg, nsel_next;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        nsel_next = nsel_reg;
        s_ready = 1'b0;
        cmd.op = bqe_pkg::OP_NOP;
        cmd.idx = idx_reg;
        cmd.nsel = nsel_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = bqe_pkg::OP_CAPTURE;
                    state_next = S_LOADT;
                end
            end
            S_LOADT: begin
                cmd.op = bqe_pkg::OP_LOAD_T;
                nsel_next = bqe_pkg::NSEL_T;
                state_next = S_MAG;
            end
            S_LOADR: begin
                cmd.op = bqe_pkg::OP_LOAD_R;
                nsel_next = bqe_pkg::NSEL_R;
                state_next = S_MAG;
            end
            S_MAG: begin
                cmd.op = bqe_pkg::OP_MAG;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (status.is_zero) begin
                    cmd.op = bqe_pkg::OP_ZERO;
                    state_next = S_NEXT;
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (status.in_range) begin
                    idx_next = 3'd0;
                    state_next = S_SQ;
                end else begin
                    cmd.op = bqe_pkg::OP_SHIFT;
                end
            end
            S_SQ: begin
                cmd.op = bqe_pkg::OP_SQ;
                if (idx_reg == 3'd2) begin
                    idx_next = 3'd0;
                    state_next = S_SQRT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SQRT: begin
                cmd.op = bqe_pkg::OP_SQRT_GO;
                state_next = S_SQW;
            end
            S_SQW: begin
                if (status.dsu_done) begin
                    cmd.op = bqe_pkg::OP_LEN;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op = bqe_pkg::OP_DIV_GO;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (status.dsu_done) begin
                    cmd.op = bqe_pkg::OP_DIV_WR;
                    if (idx_reg == 3'd2) begin
                        idx_next = 3'd0;
                        state_next = S_NEXT;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_NEXT: begin
                idx_next = 3'd0;
                unique case (nsel_reg)
                    bqe_pkg::NSEL_T: state_next = S_LOADR;
                    bqe_pkg::NSEL_R: state_next = S_CROSS;
                    default: state_next = S_HALF;
                endcase
            end
            S_CROSS: begin
                cmd.op = bqe_pkg::OP_CROSS;
                if (idx_reg == 3'd3) begin
                    idx_next = 3'd0;
                    nsel_next = bqe_pkg::NSEL_U;
                    state_next = S_MAG;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_HALF: begin
                cmd.op = bqe_pkg::OP_HALF;
                if (idx_reg == 3'd5) begin
                    idx_next = 3'd0;
                    state_next = S_ALPHA;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ALPHA: begin
                if (status.age_ge) begin
                    cmd.op = bqe_pkg::OP_ALPHA_ONE;
                    state_next = S_EMIT;
                end else begin
                    cmd.op = bqe_pkg::OP_ALPHA_GO;
                    state_next = S_ALW;
                end
            end
            S_ALW: begin
                if (status.dsu_done) begin
                    cmd.op = bqe_pkg::OP_ALPHA_WR;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op = bqe_pkg::OP_EMIT;
                    if (idx_reg == 3'd3) begin
                        idx_next = 3'd0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            idx_reg <= 3'd0;
            nsel_reg <= bqe_pkg::NSEL_T;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            nsel_reg <= nsel_next;
        end
    end

endmodule
`default_nettype wire

// File: src/billboard_quad_expander.sv
`default_nettype none
// Expands one particle into four camera-facing quad vertices, corners in the order
// (-r-u) (+r-u) (+r+u) (-r+u). A particle word is taken only while the block is idle,
// and no new word is taken until the last one's fourth vertex has been emitted. When
// the camera lies on the vertical line through the particle, the right and up axes
// come out zero. The three normalizations (to-camera, right and up axes) and the fade
// division all run one after another on a single shared iterative divide/square-root
// unit, which resolves one quotient bit or one root bit per cycle. The fade division
// is skipped when the age has reached the fade time. The four vertex words then leave
// through a one-word output register, one per cycle when the sink is ready.
// Configuration writes belong to idle periods only.
module billboard_quad_expander (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire bqe_pkg::in_word_t      s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output bqe_pkg::out_word_t          m_data,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [31:0]            cfg_wdata
);

    bqe_pkg::cmd_t      cmd;
    bqe_pkg::status_t   status;

    bqe_ctrl u_ctrl (
        .clk     (aclk),
        .rst_n   (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bqe_datapath u_datapath (
        .clk       (aclk),
        .rst_n     (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire
